@@ hdl/cpu_alu_with_flags_assert.svh @@
// Assertion helpers for the ALU block.
`ifndef CPU_ALU_WITH_FLAGS_ASSERT_SVH
`define CPU_ALU_WITH_FLAGS_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define CALU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("calu assertion failed");

// Next-cycle implication, disabled in reset.
`define CALU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("calu assertion failed");

`endif

@@ hdl/calu_pkg.sv @@
package calu_pkg;

  localparam int MODE_W  = 5;
  localparam int WORD_W  = 16;
  localparam int BYTE_W  = 8;
  localparam int BIDX_W  = 3;
  localparam int FLAGS_W = 4;

  // Bit positions inside flags_in
  localparam int FLAG_Z = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_H = 1;
  localparam int FLAG_C = 0;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD   = 5'd0,
    MODE_ADC   = 5'd1,
    MODE_SUB   = 5'd2,
    MODE_SBC   = 5'd3,
    MODE_AND   = 5'd4,
    MODE_OR    = 5'd5,
    MODE_XOR   = 5'd6,
    MODE_CP    = 5'd7,
    MODE_INC   = 5'd8,
    MODE_DEC   = 5'd9,
    MODE_RLC   = 5'd10,
    MODE_RL    = 5'd11,
    MODE_RRC   = 5'd12,
    MODE_RR    = 5'd13,
    MODE_BIT   = 5'd14,
    MODE_RES   = 5'd15,
    MODE_SET   = 5'd16,
    MODE_ADD16 = 5'd17
  } mode_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [WORD_W-1:0]  operand_a;
    logic [WORD_W-1:0]  operand_b;
    logic [BIDX_W-1:0]  bit_index;
    logic [FLAGS_W-1:0] flags_in;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] result;
    logic              zero_flag;
    logic              subtract_flag;
    logic              half_carry_flag;
    logic              carry_flag;
  } out_item_t;

endpackage

@@ hdl/calu_if.sv @@
interface calu_in_if;
  import calu_pkg::*;

  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [WORD_W-1:0]   operand_a;
  logic [WORD_W-1:0]   operand_b;
  logic [BIDX_W-1:0]   bit_index;
  logic [FLAGS_W-1:0]  flags_in;

  modport source (output valid, output mode, output operand_a, output operand_b,
                  output bit_index, output flags_in, input ready);
  modport sink   (input valid, input mode, input operand_a, input operand_b,
                  input bit_index, input flags_in, output ready);
endinterface

interface calu_out_if;
  import calu_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] result;
  logic              zero_flag;
  logic              subtract_flag;
  logic              half_carry_flag;
  logic              carry_flag;

  modport source (output valid, output result, output zero_flag, output subtract_flag,
                  output half_carry_flag, output carry_flag, input ready);
  modport sink   (input valid, input result, input zero_flag, input subtract_flag,
                  input half_carry_flag, input carry_flag, output ready);
endinterface

@@ hdl/cpu_alu_with_flags.sv @@
// Channel   Dir   Contents
// in_ch     in    mode, operand_a, operand_b, bit_index, flags_in
// out_ch    out   result, zero_flag, subtract_flag, half_carry_flag, carry_flag
//
// One beat per cycle while out_ch does not stall; a result is registered in s1_r
// and then in out_r before it is valid on out_ch.
// The ALU is a single pass of 8/16-bit adders, logic and muxes between them.
// rst_n (synchronous) empties both registers.
// A stall on out_ch holds the result register; the input register keeps
// accepting until both are full, so ready drops only with two beats in flight.
`include "cpu_alu_with_flags_assert.svh"

module cpu_alu_with_flags (
  input logic        clk,
  input logic        rst_n,
  calu_in_if.sink    in_ch,
  calu_out_if.source out_ch
);
  import calu_pkg::*;

  in_item_t  s1_r;
  in_item_t  s1_nxt;
  logic      s1_vld_r;
  out_item_t out_r;
  out_item_t alu_nxt;
  logic      out_vld_r;
  logic      out_free;
  logic      s1_adv;
  logic      in_acc;

  assign out_free    = !out_vld_r || out_ch.ready;
  assign s1_adv      = s1_vld_r && out_free;
  assign in_ch.ready = !s1_vld_r || out_free;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign s1_nxt = '{mode:      in_ch.mode,
                    operand_a: in_ch.operand_a,
                    operand_b: in_ch.operand_b,
                    bit_index: in_ch.bit_index,
                    flags_in:  in_ch.flags_in};

  always_comb begin
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] b;
    logic              fz;
    logic              fn;
    logic              fh;
    logic              fc;
    logic [BYTE_W-1:0] add_b;
    logic              add_cin;
    logic [BYTE_W:0]   add_s;
    logic [4:0]        add_hs;
    logic [BYTE_W-1:0] sub_b;
    logic              sub_cin;
    logic [BYTE_W:0]   sub_d;
    logic [4:0]        sub_hd;
    logic [WORD_W:0]   w_s;
    logic [12:0]       w_hs;
    logic [BYTE_W-1:0] r8;

    a  = s1_r.operand_a[BYTE_W-1:0];
    b  = s1_r.operand_b[BYTE_W-1:0];
    fz = s1_r.flags_in[FLAG_Z];
    fn = s1_r.flags_in[FLAG_N];
    fh = s1_r.flags_in[FLAG_H];
    fc = s1_r.flags_in[FLAG_C];

    add_b   = (s1_r.mode == MODE_INC) ? 8'h01 : b;
    add_cin = (s1_r.mode == MODE_ADC) ? fc : 1'b0;
    add_s   = {1'b0, a} + {1'b0, add_b} + {8'h00, add_cin};
    add_hs  = {1'b0, a[3:0]} + {1'b0, add_b[3:0]} + {4'h0, add_cin};

    sub_b   = (s1_r.mode == MODE_DEC) ? 8'h01 : b;
    sub_cin = (s1_r.mode == MODE_SBC) ? fc : 1'b0;
    // borrow shows as the top bit going negative
    sub_d   = {1'b0, a} - {1'b0, sub_b} - {8'h00, sub_cin};
    sub_hd  = {1'b0, a[3:0]} - {1'b0, sub_b[3:0]} - {4'h0, sub_cin};

    w_s  = {1'b0, s1_r.operand_a} + {1'b0, s1_r.operand_b};
    w_hs = {1'b0, s1_r.operand_a[11:0]} + {1'b0, s1_r.operand_b[11:0]};

    r8 = 8'h00;
    alu_nxt = '{result: s1_r.operand_a, zero_flag: fz, subtract_flag: fn,
                half_carry_flag: fh, carry_flag: fc};

    case (s1_r.mode)
      MODE_ADD, MODE_ADC: begin
        r8 = add_s[BYTE_W-1:0];
        alu_nxt.subtract_flag   = 1'b0;
        alu_nxt.half_carry_flag = add_hs[4];
        alu_nxt.carry_flag      = add_s[BYTE_W];
      end
      MODE_SUB, MODE_SBC: begin
        r8 = sub_d[BYTE_W-1:0];
        alu_nxt.subtract_flag   = 1'b1;
        alu_nxt.half_carry_flag = sub_hd[4];
        alu_nxt.carry_flag      = sub_d[BYTE_W];
      end
      MODE_AND: begin
        r8 = a & b;
        alu_nxt.subtract_flag   = 1'b0;
        alu_nxt.half_carry_flag = 1'b1;
        alu_nxt.carry_flag      = 1'b0;
      end
      MODE_OR: begin
        r8 = a | b;
        alu_nxt.subtract_flag   = 1'b0;
        alu_nxt.half_carry_flag = 1'b0;
        alu_nxt.carry_flag      = 1'b0;
      end
      MODE_XOR: begin
        r8 = a ^ b;
        alu_nxt.subtract_flag   = 1'b0;
        alu_nxt.half_carry_flag = 1'b0;
        alu_nxt.carry_flag      = 1'b0;
      end
      MODE_CP: begin
        r8 = a;
        alu_nxt.zero_flag       = (sub_d[BYTE_W-1:0] == 8'h00);
        alu_nxt.subtract_flag   = 1'b1;
        alu_nxt.half_carry_flag = sub_hd[4];
        alu_nxt.carry_flag      = sub_d[BYTE_W];
      end
      MODE_INC: begin
        r8 = add_s[BYTE_W-1:0];
        alu_nxt.subtract_flag   = 1'b0;
        alu_nxt.half_carry_flag = add_hs[4];
      end
      MODE_DEC: begin
        r8 = sub_d[BYTE_W-1:0];
        alu_nxt.subtract_flag   = 1'b1;
        alu_nxt.half_carry_flag = sub_hd[4];
      end
      MODE_RLC: begin
        r8 = {b[6:0], b[7]};
        alu_nxt.subtract_flag   = 1'b0;
        alu_nxt.half_carry_flag = 1'b0;
        alu_nxt.carry_flag      = b[7];
      end
      MODE_RL: begin
        r8 = {b[6:0], fc};
        alu_nxt.subtract_flag   = 1'b0;
        alu_nxt.half_carry_flag = 1'b0;
        alu_nxt.carry_flag      = b[7];
      end
      MODE_RRC: begin
        r8 = {b[0], b[7:1]};
        alu_nxt.subtract_flag   = 1'b0;
        alu_nxt.half_carry_flag = 1'b0;
        alu_nxt.carry_flag      = b[0];
      end
      MODE_RR: begin
        r8 = {fc, b[7:1]};
        alu_nxt.subtract_flag   = 1'b0;
        alu_nxt.half_carry_flag = 1'b0;
        alu_nxt.carry_flag      = b[0];
      end
      MODE_BIT: begin
        r8 = a;
        alu_nxt.zero_flag       = !b[s1_r.bit_index];
        alu_nxt.subtract_flag   = 1'b0;
        alu_nxt.half_carry_flag = 1'b1;
      end
      MODE_RES: r8 = b & ~(8'h01 << s1_r.bit_index);
      MODE_SET: r8 = b | (8'h01 << s1_r.bit_index);
      MODE_ADD16: begin
        alu_nxt.subtract_flag   = 1'b0;
        alu_nxt.half_carry_flag = w_hs[12];
        alu_nxt.carry_flag      = w_s[WORD_W];
      end
      default: r8 = 8'h00;
    endcase

    // Byte ops zero-extend and take Z from the byte, except where set above
    case (s1_r.mode)
      MODE_ADD, MODE_ADC, MODE_SUB, MODE_SBC, MODE_AND, MODE_OR, MODE_XOR,
      MODE_INC, MODE_DEC, MODE_RLC, MODE_RL, MODE_RRC, MODE_RR: begin
        alu_nxt.result    = {8'h00, r8};
        alu_nxt.zero_flag = (r8 == 8'h00);
      end
      MODE_CP, MODE_BIT, MODE_RES, MODE_SET: alu_nxt.result = {8'h00, r8};
      MODE_ADD16: alu_nxt.result = w_s[WORD_W-1:0];
      default: alu_nxt.result = s1_r.operand_a;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_vld_r <= in_ch.valid;
      end
      if (out_free) begin
        out_vld_r <= s1_vld_r;
      end
    end
  end

  // Payload registers: load only on a moving beat
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= s1_nxt;
    end
    if (s1_adv) begin
      out_r <= alu_nxt;
    end
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.result          = out_r.result;
  assign out_ch.zero_flag       = out_r.zero_flag;
  assign out_ch.subtract_flag   = out_r.subtract_flag;
  assign out_ch.half_carry_flag = out_r.half_carry_flag;
  assign out_ch.carry_flag      = out_r.carry_flag;

  `CALU_ASSERT_NEXT(a_s1_moves_out, clk, rst_n, s1_adv, out_vld_r)
  `CALU_ASSERT_NOW(a_stall_only_full, clk, rst_n, !in_ch.ready, s1_vld_r && out_vld_r)
  `CALU_ASSERT_NOW(a_no_overwrite, clk, rst_n, in_acc && s1_vld_r, s1_adv)
  `CALU_ASSERT_NEXT(a_result_loaded, clk, rst_n, s1_adv, out_r == $past(alu_nxt))

endmodule
